// File: rtl/tkin_pkg.sv
// ============================================================================
// Track kinematics package
// Shared payload types, widths and constant tables for the track kinematics
// pipeline.
// ============================================================================
package tkin_pkg;

    // One request on the input channel.
    typedef struct packed {
        logic signed [15:0] mom_x;
        logic signed [15:0] mom_y;
        logic signed [15:0] mom_z;
    } in_item_t;

    // One request on the result channel.
    typedef struct packed {
        logic        [15:0] trans_mom;
        logic        [15:0] total_mom;
        logic        [15:0] polar;
        logic signed [15:0] pseudo_rap;
        logic               undefined_flag;
    } out_item_t;

    // Square root unit: 32-bit radicand scaled by 2^16, 24-bit root.
    localparam int RAD_W  = 32;
    localparam int ROOT_W = 24;
    localparam int REM_W  = 26;

    // Logarithm unit.
    localparam int LOG_IN_W = 25;
    localparam int EXP_W    = 5;
    localparam int MANT_W   = 31;
    localparam int LOG_FRAC = 16;
    localparam int LOG_W    = EXP_W + LOG_FRAC;
    localparam int LN2_W    = 30;
    localparam int PROD_W   = LOG_W + LN2_W;
    localparam int MAG_W    = 17;
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

    // Angle unit.
    localparam int CX_W        = 27;
    localparam int PHI_W       = 32;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [PHI_W-1:0] HALF_PI_Q30 = 32'sd1686629713;
    localparam logic [15:0] HALF_PI_Q14 = 16'd25736;
    localparam logic [15:0] PI_Q14      = 16'd51472;

    // atan(2^-i) scaled by 2^30, truncated.
    localparam logic [PHI_W-1:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

endpackage

// File: rtl/track_kinematics_core.sv
// ============================================================================
// Track kinematics core
// Transverse momentum, total momentum, polar angle and pseudorapidity of one
// track from its momentum components.
// ============================================================================
// CORDIC_STEPS is taken as 1..24. Throughput: one track per cycle unless a
// finished result waits on a consumer that is not ready; every stage is
// a register and the whole pipeline advances together. The 24-stage root unit
// and the 16 squaring stages of the log unit make up most of the stages.
// Reset (aresetn low at a clock edge) clears all valid bits; nothing else.
module track_kinematics_core import tkin_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Per-track flags and |z| that ride along the pipeline.
    typedef struct packed {
        logic [15:0] az;
        logic        zneg;
        logic        zzero;
        logic        s2zero;
    } base_t;

    typedef struct packed {
        logic [15:0]       pt;
        logic [15:0]       p;
        logic [ROOT_W-1:0] ptf;
        base_t             base;
    } lg_side_t;

    typedef struct packed {
        logic [15:0]        pt;
        logic [15:0]        p;
        logic signed [15:0] eta;
        base_t              base;
    } cr_side_t;

    // A single enable moves every stage; the pipeline stalls only when a
    // finished result is waiting and the consumer is not ready.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------------------------------------------------------------
    // Stage 1: squares of the components and |z|.
    // ---------------------------------------------------------------------
    logic               v1_reg;
    logic [30:0]        sq_x_reg, sq_y_reg, sq_z_reg;
    logic [15:0]        az1_reg;
    logic               zneg1_reg, zzero1_reg;
    logic signed [31:0] px_sq, py_sq, pz_sq;

    assign px_sq = s_data.mom_x * s_data.mom_x;
    assign py_sq = s_data.mom_y * s_data.mom_y;
    assign pz_sq = s_data.mom_z * s_data.mom_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg   <= px_sq[30:0];
            sq_y_reg   <= py_sq[30:0];
            sq_z_reg   <= pz_sq[30:0];
            // Negating -32768 wraps to 16'h8000, which is 32768 unsigned.
            az1_reg    <= s_data.mom_z[15] ? 16'(~s_data.mom_z + 16'sd1)
                                           : 16'(s_data.mom_z);
            zneg1_reg  <= s_data.mom_z[15];
            zzero1_reg <= (s_data.mom_z == '0);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: sums of squares for the transverse and total momentum.
    // ---------------------------------------------------------------------
    logic        v2_reg;
    logic [31:0] s2_reg, s3_reg;
    logic [31:0] s2_next;
    base_t       base2_reg;

    assign s2_next = 32'(sq_x_reg) + 32'(sq_y_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg           <= s2_next;
            s3_reg           <= s2_next + 32'(sq_z_reg);
            base2_reg.az     <= az1_reg;
            base2_reg.zneg   <= zneg1_reg;
            base2_reg.zzero  <= zzero1_reg;
            base2_reg.s2zero <= (s2_next == '0);
        end
    end

    // ---------------------------------------------------------------------
    // Square roots with eight extra fraction bits: lane 0 gives pt, lane 1 p.
    // ---------------------------------------------------------------------
    logic                  sq_valid;
    logic [1:0][ROOT_W-1:0] roots;
    base_t                 sq_base;

    tkin_sqrt #(
        .SIDE_W ($bits(base_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_rad    ({s3_reg, s2_reg}),
        .in_side   (base2_reg),
        .out_valid (sq_valid),
        .out_root  (roots),
        .out_side  (sq_base)
    );

    // ---------------------------------------------------------------------
    // Stage 3: rounded magnitudes and the log numerator pf + |z| * 2^8.
    // The fraction bit just below the point gives round half up exactly.
    // ---------------------------------------------------------------------
    logic                v3_reg;
    logic [LOG_IN_W-1:0] num3_reg;
    lg_side_t            lg3_reg;
    logic [LOG_IN_W-1:0] pt_sum, p_sum;

    assign pt_sum = LOG_IN_W'(roots[0]) + LOG_IN_W'(128);
    assign p_sum  = LOG_IN_W'(roots[1]) + LOG_IN_W'(128);

    always_ff @(posedge aclk) begin
        if (en) begin
            num3_reg     <= LOG_IN_W'(roots[1]) + LOG_IN_W'({sq_base.az, 8'h00});
            lg3_reg.pt   <= pt_sum[23:8];
            lg3_reg.p    <= p_sum[23:8];
            lg3_reg.ptf  <= roots[0];
            lg3_reg.base <= sq_base;
        end
    end

    // ---------------------------------------------------------------------
    // |eta| = ln((p + |z|) / pt).
    // ---------------------------------------------------------------------
    logic        lg_valid;
    logic [MAG_W-1:0] mag;
    lg_side_t    lg_side;

    tkin_log2 #(
        .SIDE_W ($bits(lg_side_t))
    ) u_log2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_val    ({LOG_IN_W'(lg3_reg.ptf), num3_reg}),
        .in_side   (lg3_reg),
        .out_valid (lg_valid),
        .out_mag   (mag),
        .out_side  (lg_side)
    );

    // ---------------------------------------------------------------------
    // Stage 4: sign and saturation of eta; CORDIC operands.
    // ---------------------------------------------------------------------
    logic              v4_reg;
    cr_side_t          cr4_reg;
    logic [ROOT_W-1:0] ptf4_reg;
    logic signed [15:0] eta_next;

    always_comb begin
        if (lg_side.base.zneg) begin
            eta_next = (mag > MAG_W'(32768)) ? 16'sh8000 : 16'(~mag + MAG_W'(1));
        end else begin
            eta_next = (mag > MAG_W'(32767)) ? 16'sh7FFF : 16'(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cr4_reg.pt   <= lg_side.pt;
            cr4_reg.p    <= lg_side.p;
            cr4_reg.eta  <= eta_next;
            cr4_reg.base <= lg_side.base;
            ptf4_reg     <= lg_side.ptf;
        end
    end

    // ---------------------------------------------------------------------
    // phi = atan2(pt, |z|), Q14, in 0..pi/2.
    // ---------------------------------------------------------------------
    logic        cr_valid;
    logic [15:0] phi14;
    cr_side_t    cr_side;

    tkin_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W ($bits(cr_side_t))
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_x      ({cr4_reg.base.az, 8'h00}),
        .in_y      (ptf4_reg),
        .in_side   (cr4_reg),
        .out_valid (cr_valid),
        .out_phi   (phi14),
        .out_side  (cr_side)
    );

    // ---------------------------------------------------------------------
    // Output register: theta from phi by the sign of z, and the special case
    // of zero transverse momentum, where eta is pinned to its limit and theta
    // to the beam direction (zero eta and pi/2 for a zero momentum vector).
    // ---------------------------------------------------------------------
    logic      m_valid_reg;
    out_item_t m_data_reg;
    out_item_t out_next;

    always_comb begin
        out_next.trans_mom      = cr_side.pt;
        out_next.total_mom      = cr_side.p;
        out_next.undefined_flag = cr_side.base.s2zero;
        if (cr_side.base.s2zero) begin
            if (cr_side.base.zzero) begin
                out_next.polar      = HALF_PI_Q14;
                out_next.pseudo_rap = '0;
            end else if (cr_side.base.zneg) begin
                out_next.polar      = PI_Q14;
                out_next.pseudo_rap = 16'sh8000;
            end else begin
                out_next.polar      = '0;
                out_next.pseudo_rap = 16'sh7FFF;
            end
        end else begin
            out_next.polar      = cr_side.base.zneg ? (PI_Q14 - phi14) : phi14;
            out_next.pseudo_rap = cr_side.eta;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= out_next;
        end
    end

    // Valid bits of the stages owned here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= sq_valid;
            v4_reg      <= lg_valid;
            m_valid_reg <= cr_valid;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // The flag marks exactly the tracks whose rounded pt is zero.
    a_flag_pt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.undefined_flag == (m_data.trans_mom == '0)))
        else $error("undefined_flag does not match trans_mom");

    // The polar angle never exceeds pi.
    a_polar_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.polar <= PI_Q14))
        else $error("polar angle above pi");

    // Total momentum is never below transverse momentum.
    a_mom_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.total_mom >= m_data.trans_mom))
        else $error("total_mom below trans_mom");

    // A zero momentum vector reports pi/2 and zero eta.
    a_zero_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.undefined_flag && (m_data.polar == HALF_PI_Q14))
        |-> (m_data.pseudo_rap == '0))
        else $error("zero momentum vector with nonzero eta");

    // A result stalled by the consumer stays in place.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

// File: rtl/tkin_sqrt.sv
// ============================================================================
// Pipelined square root, two lanes
// Digit-by-digit integer root of (radicand * 2^16), one root bit per stage.
// ============================================================================
module tkin_sqrt import tkin_pkg::*; #(
    parameter int SIDE_W = 19
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [1:0][RAD_W-1:0]        in_rad,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [1:0][ROOT_W-1:0]       out_root,
    output logic [SIDE_W-1:0]            out_side
);

    logic [ROOT_W:1]    valid_reg;
    logic [SIDE_W-1:0]  side_reg [1:ROOT_W];
    logic [RAD_W-1:0]   rad_reg  [1:ROOT_W][0:1];
    logic [REM_W-1:0]   rem_reg  [1:ROOT_W][0:1];
    logic [ROOT_W-1:0]  root_reg [1:ROOT_W][0:1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_in;
        logic [SIDE_W-1:0] side_in;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[k];
            assign side_in = side_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_in;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [RAD_W-1:0]  rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [1:0]        pair;
            logic [REM_W+1:0]  trial;
            logic [REM_W+1:0]  sub;
            logic              ge;

            if (k == 0) begin : g_first
                assign rad_in  = in_rad[l];
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign rad_in  = rad_reg[k][l];
                assign rem_in  = rem_reg[k][l];
                assign root_in = root_reg[k][l];
            end

            // The low 16 bits of the scaled radicand are zero.
            if (2 * k + 1 < RAD_W) begin : g_pair
                assign pair = rad_in[RAD_W-1-2*k -: 2];
            end else begin : g_zero
                assign pair = 2'b00;
            end

            assign trial = {rem_in, pair};
            assign sub   = {2'b00, root_in, 2'b01};
            assign ge    = (trial >= sub);

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k+1][l]  <= rad_in;
                    rem_reg[k+1][l]  <= ge ? REM_W'(trial - sub) : REM_W'(trial);
                    root_reg[k+1][l] <= {root_in[ROOT_W-2:0], ge};
                end
            end
        end
    end

    assign out_valid   = valid_reg[ROOT_W];
    assign out_side    = side_reg[ROOT_W];
    assign out_root[0] = root_reg[ROOT_W][0];
    assign out_root[1] = root_reg[ROOT_W][1];

endmodule

// File: rtl/tkin_log2.sv
// ============================================================================
// Pipelined log ratio
// Natural log of lane0 / lane1 through Q16 base-2 logs by repeated squaring.
// ============================================================================
module tkin_log2 import tkin_pkg::*; #(
    parameter int SIDE_W = 75
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [1:0][LOG_IN_W-1:0]     in_val,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [MAG_W-1:0]             out_mag,
    output logic [SIDE_W-1:0]            out_side
);

    localparam int NS = LOG_FRAC + 4;

    logic [NS-1:0]       valid_reg;
    logic [SIDE_W-1:0]   side_reg  [0:NS-1];
    logic [LOG_IN_W-1:0] x0_reg    [0:1];
    logic [EXP_W-1:0]    e0_reg    [0:1];
    logic [MANT_W-1:0]   m_reg     [0:LOG_FRAC][0:1];
    logic [EXP_W-1:0]    exp_reg   [0:LOG_FRAC][0:1];
    logic [LOG_FRAC-1:0] frac_reg  [0:LOG_FRAC][0:1];
    logic [LOG_W-1:0]    d_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W:0]     rounded;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int i = 1; i < NS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [EXP_W-1:0]  e_next;
        logic [MANT_W-1:0] m_norm;

        // Position of the leading one.
        always_comb begin
            e_next = '0;
            for (int i = 0; i < LOG_IN_W; i++) begin
                if (in_val[l][i]) begin
                    e_next = EXP_W'(i);
                end
            end
        end

        assign m_norm = MANT_W'(x0_reg[l]) << (EXP_W'(MANT_W - 1) - e0_reg[l]);

        always_ff @(posedge aclk) begin
            if (en) begin
                x0_reg[l]      <= in_val[l];
                e0_reg[l]      <= e_next;
                m_reg[0][l]    <= m_norm;
                exp_reg[0][l]  <= e0_reg[l];
                frac_reg[0][l] <= '0;
            end
        end

        // Each squaring yields one fraction bit of the log.
        for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_sq
            logic [2*MANT_W-1:0] prod;
            logic [MANT_W:0]     sq;

            assign prod = m_reg[j-1][l] * m_reg[j-1][l];
            assign sq   = prod[2*MANT_W-1:MANT_W-1];

            always_ff @(posedge aclk) begin
                if (en) begin
                    exp_reg[j][l] <= exp_reg[j-1][l];
                    if (sq[MANT_W]) begin
                        m_reg[j][l]    <= sq[MANT_W:1];
                        frac_reg[j][l] <= frac_reg[j-1][l] | (LOG_FRAC'(1) << (LOG_FRAC - j));
                    end else begin
                        m_reg[j][l]    <= sq[MANT_W-1:0];
                        frac_reg[j][l] <= frac_reg[j-1][l];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= {exp_reg[LOG_FRAC][0], frac_reg[LOG_FRAC][0]}
                      - {exp_reg[LOG_FRAC][1], frac_reg[LOG_FRAC][1]};
            prod_reg <= PROD_W'(d_reg) * PROD_W'(LN2_Q30);
        end
    end

    // Round half up from Q46 to Q12.
    assign rounded   = {1'b0, prod_reg} + ((PROD_W+1)'(1) << 33);
    assign out_mag   = rounded[34 +: MAG_W];
    assign out_valid = valid_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// File: rtl/tkin_cordic.sv
// ============================================================================
// Pipelined vectoring CORDIC
// Angle atan2(y, x) for x >= 0, one rotation per stage, Q14 result.
// ============================================================================
module tkin_cordic import tkin_pkg::*; #(
    parameter int STEPS  = 16,
    parameter int SIDE_W = 51
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [ROOT_W-1:0]    in_x,
    input  logic [ROOT_W-1:0]    in_y,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [15:0]          out_phi,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int S  = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : ((STEPS < 1) ? 1 : STEPS);
    localparam int NS = S + 1;

    logic [NS-1:0]            valid_reg;
    logic [SIDE_W-1:0]        side_reg [0:NS-1];
    logic signed [CX_W-1:0]   cx_reg   [1:S];
    logic signed [CX_W-1:0]   cy_reg   [1:S];
    logic signed [PHI_W-1:0]  phi_reg  [1:S];
    logic [15:0]              phi14_reg;

    logic [PHI_W-1:0]         phi_c;
    logic [PHI_W-1:0]         phi_rnd;
    logic [15:0]              phi14;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int i = 1; i < NS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_step
        logic signed [CX_W-1:0]  cx_in;
        logic signed [CX_W-1:0]  cy_in;
        logic signed [PHI_W-1:0] phi_in;
        logic signed [CX_W-1:0]  dx;
        logic signed [CX_W-1:0]  dy;

        if (k == 0) begin : g_first
            assign cx_in  = signed'(CX_W'(in_x));
            assign cy_in  = signed'(CX_W'(in_y));
            assign phi_in = '0;
        end else begin : g_next
            assign cx_in  = cx_reg[k];
            assign cy_in  = cy_reg[k];
            assign phi_in = phi_reg[k];
        end

        assign dx = cy_in >>> k;
        assign dy = cx_in >>> k;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (cy_in > 0) begin
                    cx_reg[k+1]  <= cx_in + dx;
                    cy_reg[k+1]  <= cy_in - dy;
                    phi_reg[k+1] <= phi_in + signed'(ATAN_TAB[k]);
                end else begin
                    cx_reg[k+1]  <= cx_in - dx;
                    cy_reg[k+1]  <= cy_in + dy;
                    phi_reg[k+1] <= phi_in - signed'(ATAN_TAB[k]);
                end
            end
        end
    end

    // Clamp to 0..pi/2, round half up to Q14, clamp again.
    always_comb begin
        if (phi_reg[S] < 0) begin
            phi_c = '0;
        end else if (phi_reg[S] > HALF_PI_Q30) begin
            phi_c = HALF_PI_Q30;
        end else begin
            phi_c = phi_reg[S];
        end
        phi_rnd = phi_c + PHI_W'(32'h0000_8000);
        phi14   = (phi_rnd[31:16] > HALF_PI_Q14) ? HALF_PI_Q14 : phi_rnd[31:16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            phi14_reg <= phi14;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_phi   = phi14_reg;
    assign out_side  = side_reg[NS-1];

endmodule

// File: bench/tb_track_kinematics_core.sv
// ============================================================================
// Track kinematics core testbench
// Drives momentum requests through the kinematics pipeline with bursty input
// and a stalling receiver, predicts every result with an independent
// fixed-point model, and compares each result request with its prediction.
// ============================================================================
module tb_track_kinematics_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tkin_pkg::*;

    localparam int STEPS       = 16;
    localparam int LATENCY     = STEPS + 50;
    localparam int N_RANDOM    = 800;
    localparam int CYCLE_LIMIT = 400000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    track_kinematics_core #(.CORDIC_STEPS(STEPS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Tracks waiting to be driven, and kinematics expected back in order.
    in_item_t  track_queue[$];
    out_item_t kin_expected[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        stimulus_done = 1'b0;

    // Angle table atan(2^-i) in Q30, truncated.
    localparam longint ATAN_Q30 [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned rounded_root(longint unsigned n);
        longint unsigned r;
        r = int_root(n);
        if (n - r * r > r) r++;
        return r;
    endfunction

    // Base-2 logarithm in Q16 by normalizing to Q30 and repeated squaring.
    function automatic longint unsigned log2_fixed(longint unsigned v);
        int unsigned     e;
        longint unsigned m, frac;
        e = 0;
        frac = 0;
        while (e < 63 && (v >> (e + 1)) != 0) e++;
        m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int i = 1; i <= 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m >>= 1;
                frac |= 64'd1 << (16 - i);
            end
        end
        return (longint'(e) << 16) | frac;
    endfunction

    function automatic out_item_t predict_kinematics(in_item_t trk);
        out_item_t       res;
        longint          x, y, z, cx, cy, nx, ny, phi;
        longint unsigned az, s2, s3, ptf, pf, d, mag, phi14;
        x = trk.mom_x;
        y = trk.mom_y;
        z = trk.mom_z;
        az = (z < 0) ? -z : z;
        s2 = x * x + y * y;
        s3 = s2 + az * az;
        res = '0;
        res.trans_mom = 16'(rounded_root(s2));
        res.total_mom = 16'(rounded_root(s3));
        if (s2 == 0) begin
            // Along the beam axis or a null vector: eta is undefined.
            res.undefined_flag = 1'b1;
            if (z > 0) begin
                res.polar = 16'd0;
                res.pseudo_rap = 16'sh7FFF;
            end else if (z < 0) begin
                res.polar = PI_Q14;
                res.pseudo_rap = 16'sh8000;
            end else begin
                res.polar = HALF_PI_Q14;
                res.pseudo_rap = 16'sd0;
            end
        end else begin
            ptf = int_root(s2 << 16);
            pf = int_root(s3 << 16);
            d = log2_fixed(pf + (az << 8)) - log2_fixed(ptf);
            mag = (d * 64'd744261118 + (64'd1 << 33)) >> 34;
            cx = az << 8;
            cy = ptf;
            phi = 0;
            for (int i = 0; i < STEPS; i++) begin
                if (cy > 0) begin
                    nx = cx + (cy >>> i);
                    ny = cy - (cx >>> i);
                    phi += ATAN_Q30[i];
                end else begin
                    nx = cx - (cy >>> i);
                    ny = cy + (cx >>> i);
                    phi -= ATAN_Q30[i];
                end
                cx = nx;
                cy = ny;
            end
            if (phi < 0) phi = 0;
            if (phi > 64'd1686629713) phi = 64'd1686629713;
            phi14 = (longint'(phi) + (64'd1 << 15)) >> 16;
            if (phi14 > HALF_PI_Q14) phi14 = HALF_PI_Q14;
            res.polar = (z < 0) ? PI_Q14 - phi14[15:0] : phi14[15:0];
            if (z < 0)
                res.pseudo_rap = (mag > 32768) ? 16'sh8000 : -mag[15:0];
            else
                res.pseudo_rap = (mag > 32767) ? 16'sh7FFF : mag[15:0];
        end
        return res;
    endfunction

    function automatic in_item_t make_track(int x, int y, int z);
        in_item_t t;
        t.mom_x = x[15:0];
        t.mom_y = y[15:0];
        t.mom_z = z[15:0];
        return t;
    endfunction

    // Random component: full range half the time, otherwise tiny, small or extreme
    // values, so that large and saturated pseudorapidity both occur.
    function automatic int rand_component();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 6) - 3;
            1: return $urandom_range(0, 1) ? 32767 : -32768;
            2: return $urandom_range(0, 200) - 100;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Stimulus: directed corner tracks first, then random tracks.
    initial begin
        track_queue.push_back(make_track(0, 0, 0));
        track_queue.push_back(make_track(0, 0, 1));
        track_queue.push_back(make_track(0, 0, -1));
        track_queue.push_back(make_track(0, 0, 32767));
        track_queue.push_back(make_track(0, 0, -32768));
        track_queue.push_back(make_track(1, 0, 0));
        track_queue.push_back(make_track(0, -1, 0));
        track_queue.push_back(make_track(1, 0, 32767));
        track_queue.push_back(make_track(-1, 0, -32768));
        track_queue.push_back(make_track(-32768, -32768, -32768));
        track_queue.push_back(make_track(32767, 32767, 32767));
        track_queue.push_back(make_track(-32768, 0, 0));
        track_queue.push_back(make_track(0, 32767, -32768));
        track_queue.push_back(make_track(3, 4, 0));
        track_queue.push_back(make_track(3, 4, 12));
        track_queue.push_back(make_track(1, 1, 0));
        track_queue.push_back(make_track(100, -100, -5));
        track_queue.push_back(make_track(-32768, 32767, 1));
        track_queue.push_back(make_track(12345, -23456, -32768));
        track_queue.push_back(make_track(21845, -21846, 10922));
        for (int i = 0; i < N_RANDOM; i++)
            track_queue.push_back(make_track(rand_component(), rand_component(),
                                             rand_component()));
        stimulus_done = 1'b1;
    end

    // Input handshake as seen at the rising edge.
    bit in_taken = 1'b0;

    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
    end

    // Driver: bursts of requests separated by random gaps. Inputs change on
    // the falling edge, so the rising edge sees settled values.
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                kin_expected.push_back(predict_kinematics(s_data));
                void'(track_queue.pop_front());
            end
            // A held request stays unchanged until accepted.
            if (!s_valid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (track_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= track_queue[0];
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: long ready stretches broken by stall runs.
    int stall_phase = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            stall_phase = (stall_phase + 1) % 37;
            if (stall_phase < 20)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 2) != 0) ? 1'b0 : 1'b1;
        end
    end

    // Monitor: compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (kin_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result request: %p", m_data);
            end else begin
                want = kin_expected.pop_front();
                if (m_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    // Reset, end of run and watchdog.
    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (!(stimulus_done && track_queue.size() == 0 && !s_valid
                 && kin_expected.size() == 0) && cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout waiting for results");
            $display("Testbench completed WITH ERRORS");
        end else begin
            // Let any stray result surface before judging.
            repeat (LATENCY + 20) @(posedge aclk);
            if (mismatch_count == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
